// ===== rtl/core/iwms_pkg.sv =====
// Shared types, kind codes and timing constants of the issue window makespan block.
package iwms_pkg;

	localparam int KindW   = 4;
	localparam int CountW  = 4;
	localparam int IndexW  = 12;
	localparam int FieldsN = 8;
	localparam int SpanW   = 16;
	localparam int WinW    = 13;

	typedef logic [KindW-1:0]  kind_t;
	typedef logic [CountW-1:0] count_t;
	typedef logic [IndexW-1:0] index_t;

	localparam kind_t K_CONST = 4'd0;
	localparam kind_t K_LOAD  = 4'd1;
	localparam kind_t K_STORE = 4'd2;
	localparam kind_t K_MUL   = 4'd3;
	localparam kind_t K_FMA   = 4'd4;
	localparam kind_t K_DMF   = 4'd5;
	localparam kind_t K_ADD   = 4'd6;
	localparam kind_t K_NEG   = 4'd7;
	localparam kind_t K_OTHER = 4'd8;

	localparam int LatLoad  = 5;
	localparam int LatStore = 1;
	localparam int LatOther = 4;
	localparam int MaxLat   = 5;

	localparam logic [1:0] LoadPorts  = 2'd3;
	localparam logic [1:0] StorePorts = 2'd2;
	localparam logic [2:0] MulUnits   = 3'd2;
	localparam logic [2:0] FpUnits    = 3'd3;

	function automatic logic [2:0] latency_of(input kind_t k);
		logic [2:0] r;
		unique case (k)
			K_CONST: r = 3'd0;
			K_LOAD:  r = 3'(LatLoad);
			K_STORE: r = 3'(LatStore);
			default: r = 3'(LatOther);
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/core/iwms_ifs.sv =====
// Valid/ready channels for operation items and makespan results.
interface iwms_op_if;
	import iwms_pkg::*;
	logic   valid;
	logic   ready;
	kind_t  op_kind;
	count_t operand_count;
	index_t operand_0;
	index_t operand_1;
	index_t operand_2;
	index_t operand_3;
	index_t operand_4;
	index_t operand_5;
	index_t operand_6;
	index_t operand_7;
	logic   last_op;
	modport source (output valid, op_kind, operand_count, operand_0, operand_1, operand_2,
		operand_3, operand_4, operand_5, operand_6, operand_7, last_op, input ready);
	modport sink (input valid, op_kind, operand_count, operand_0, operand_1, operand_2,
		operand_3, operand_4, operand_5, operand_6, operand_7, last_op, output ready);
endinterface

interface iwms_res_if;
	import iwms_pkg::*;
	logic             valid;
	logic             ready;
	logic [SpanW-1:0] makespan;
	logic             horizon_overflow;
	modport source (output valid, makespan, horizon_overflow, input ready);
	modport sink (input valid, makespan, horizon_overflow, output ready);
endinterface

// ===== rtl/core/iwms_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module iwms_ram #(
	parameter int W = 8,
	parameter int D = 16
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);
	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== rtl/core/issue_window_makespan_sim.sv =====
// Top level: operation loader and cycle-by-cycle issue simulator.
// Sequence: an item is stored, then its operands in turn; the closing item then starts the
//   clearing sweep, then per simulated cycle the head steps, each window entry is read and,
//   for an unissued one, its operands are checked, all through one finish-time RAM port;
//   the result is then registered.
// Throughput: one run at a time; not ready while loading, simulating or storing a result.
// Reset (arst_n low): sequencer idle, entry count zero, window_size zero, no result pending.
//   Stores are not cleared; the issued flags are swept at the start of every run.
module issue_window_makespan_sim #(
	parameter int MAX_OPS      = 4096,
	parameter int HORIZON      = 32768,
	parameter int MAX_OPERANDS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	iwms_op_if.sink     op_in,
	iwms_res_if.source  res_out,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import iwms_pkg::*;

	localparam int IW   = $clog2(MAX_OPS);
	localparam int CW   = $clog2(MAX_OPS + 1);
	localparam int SW   = (MAX_OPERANDS > 1) ? $clog2(MAX_OPERANDS) : 1;
	localparam int TW   = $clog2(HORIZON + 1);
	localparam int FW   = $clog2(HORIZON + MaxLat + 1);
	localparam int LW   = ((CW > WinW) ? CW : WinW) + 1;
	localparam int CMAX = (MAX_OPERANDS < FieldsN) ? MAX_OPERANDS : FieldsN;

	typedef enum logic [3:0] {
		S_IDLE, S_LOAD, S_CLR, S_HEAD_RD, S_HEAD_CHK, S_SCAN_RD, S_SCAN_CHK,
		S_OPD_RD, S_OPD_CHK, S_DEP_CHK, S_ISSUE, S_END, S_FIN
	} state_t;

	state_t state_q;

	// configuration
	logic [WinW-1:0] win_q;
	assign pready = 1'b1;
	assign prdata = (paddr[2] == 1'b0) ? 32'(win_q) : 32'd0;

	// load side
	logic [CW-1:0]   cnt_q;        // entries loaded (m during a run)
	logic [IW-1:0]   ld_idx_q;
	logic            ld_room_q;
	logic            ld_last_q;
	count_t          ld_cnt_q;
	index_t          ld_opd_q [FieldsN];
	count_t          j_q;

	// run state
	logic [CW-1:0]   head_q, s_q, lim_q, issued_q, clr_q;
	logic [TW-1:0]   t_q;
	logic [FW-1:0]   mk_q;
	logic            any_q, ov_q;
	logic [1:0]      ldu_q, stu_q;
	logic [2:0]      mfu_q, fpu_q;
	kind_t           cur_kind_q;
	count_t          cur_cnt_q;

	// output register
	logic            out_vq;
	logic [15:0]     out_mk_q;
	logic            out_ov_q;

	assign res_out.valid            = out_vq;
	assign res_out.makespan         = out_mk_q;
	assign res_out.horizon_overflow = out_ov_q;
	assign op_in.ready              = (state_q == S_IDLE);

	logic acc;
	assign acc = op_in.valid && op_in.ready;

	// input conditioning
	kind_t  in_kind;
	count_t in_cnt;
	assign in_kind = (op_in.op_kind > K_OTHER) ? K_OTHER : op_in.op_kind;
	assign in_cnt  = (op_in.operand_count > count_t'(CMAX)) ? count_t'(CMAX) : op_in.operand_count;

	logic room;
	assign room = (32'(cnt_q) < 32'(MAX_OPS));

	// memories
	kind_t        kind_rd;
	count_t       ocnt_rd;
	index_t       opd_rd;
	logic [FW:0]  fin_rd;
	logic         fin_we;
	logic [IW-1:0] fin_waddr, fin_raddr;
	logic [FW:0]  fin_wdata;
	logic         opd_we;

	iwms_ram #(.W(KindW), .D(MAX_OPS)) u_kind (
		.clk(clk), .we(acc && room), .waddr(cnt_q[IW-1:0]), .wdata(in_kind),
		.raddr(s_q[IW-1:0]), .rdata(kind_rd));

	iwms_ram #(.W(CountW), .D(MAX_OPS)) u_ocnt (
		.clk(clk), .we(acc && room), .waddr(cnt_q[IW-1:0]), .wdata(in_cnt),
		.raddr(s_q[IW-1:0]), .rdata(ocnt_rd));

	assign opd_we = (state_q == S_LOAD) && ld_room_q && (j_q < ld_cnt_q);

	iwms_ram #(.W(IndexW), .D(MAX_OPS << SW)) u_opd (
		.clk(clk), .we(opd_we), .waddr({ld_idx_q, j_q[SW-1:0]}), .wdata(ld_opd_q[j_q[2:0]]),
		.raddr({s_q[IW-1:0], j_q[SW-1:0]}), .rdata(opd_rd));

	iwms_ram #(.W(FW + 1), .D(MAX_OPS)) u_fin (
		.clk(clk), .we(fin_we), .waddr(fin_waddr), .wdata(fin_wdata),
		.raddr(fin_raddr), .rdata(fin_rd));

	// issue decision for the entry under scan
	logic       need_m, need_f2, need_f1;
	logic [2:0] um, uf;
	logic       port_ok;
	logic [FW-1:0] fin_new;

	always_comb begin
		need_m  = (cur_kind_q == K_MUL) || (cur_kind_q == K_FMA);
		need_f2 = (cur_kind_q == K_DMF);
		need_f1 = need_m || (cur_kind_q == K_ADD) || (cur_kind_q == K_NEG);
		um = need_f2 ? 3'd2 : (need_m ? 3'd1 : 3'd0);
		uf = need_f2 ? 3'd2 : (need_f1 ? 3'd1 : 3'd0);
		priority if (cur_kind_q == K_CONST) begin
			port_ok = 1'b1;
		end else if (cur_kind_q == K_LOAD) begin
			port_ok = (ldu_q < LoadPorts);
		end else if (cur_kind_q == K_STORE) begin
			port_ok = (stu_q < StorePorts);
		end else begin
			port_ok = ((mfu_q + um) <= MulUnits) && ((fpu_q + uf) <= FpUnits);
		end
		fin_new = FW'(t_q) + FW'(latency_of(cur_kind_q));
	end

	// finish RAM ports: sweep writes during clearing, issue writes during the scan
	always_comb begin
		fin_we    = 1'b0;
		fin_waddr = s_q[IW-1:0];
		fin_wdata = {1'b1, fin_new};
		if (state_q == S_CLR) begin
			fin_we    = (clr_q < cnt_q);
			fin_waddr = clr_q[IW-1:0];
			fin_wdata = '0;
		end else if (state_q == S_ISSUE) begin
			fin_we    = port_ok;
		end
		unique case (state_q)
			S_HEAD_RD: fin_raddr = head_q[IW-1:0];
			S_OPD_CHK: fin_raddr = IW'(opd_rd);
			default:   fin_raddr = s_q[IW-1:0];
		endcase
	end

	// window limit from the head
	logic [LW-1:0] win_end;
	assign win_end = LW'(head_q) + LW'(win_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			win_q     <= '0;
			cnt_q     <= '0;
			out_vq    <= 1'b0;
			ld_room_q <= 1'b0;
			ld_last_q <= 1'b0;
			ld_cnt_q  <= '0;
			j_q       <= '0;
		end else begin
			if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
				win_q <= pwdata[WinW-1:0];
			end
			// in S_FIN the result register is reloaded below instead
			if (res_out.valid && res_out.ready && (state_q != S_FIN)) begin
				out_vq <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (acc) begin
						ld_idx_q  <= cnt_q[IW-1:0];
						ld_room_q <= room;
						ld_last_q <= op_in.last_op;
						ld_cnt_q  <= in_cnt;
						ld_opd_q[0] <= op_in.operand_0;
						ld_opd_q[1] <= op_in.operand_1;
						ld_opd_q[2] <= op_in.operand_2;
						ld_opd_q[3] <= op_in.operand_3;
						ld_opd_q[4] <= op_in.operand_4;
						ld_opd_q[5] <= op_in.operand_5;
						ld_opd_q[6] <= op_in.operand_6;
						ld_opd_q[7] <= op_in.operand_7;
						j_q <= '0;
						if (room) begin
							cnt_q <= cnt_q + 1'b1;
						end
						state_q <= S_LOAD;
					end
				end
				S_LOAD: begin
					if (ld_room_q && (j_q < ld_cnt_q)) begin
						j_q <= j_q + 1'b1;
					end else if (ld_last_q) begin
						clr_q   <= '0;
						state_q <= S_CLR;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_CLR: begin
					if (clr_q < cnt_q) begin
						clr_q <= clr_q + 1'b1;
					end else begin
						head_q   <= '0;
						issued_q <= '0;
						t_q      <= '0;
						mk_q     <= '0;
						ov_q     <= 1'b0;
						state_q  <= (cnt_q == '0) ? S_FIN : S_HEAD_RD;
					end
				end
				S_HEAD_RD: begin
					state_q <= S_HEAD_CHK;
				end
				S_HEAD_CHK: begin
					if ((head_q < cnt_q) && fin_rd[FW]) begin
						head_q  <= head_q + 1'b1;
						state_q <= S_HEAD_RD;
					end else begin
						if ((win_q == '0) || (win_end > LW'(cnt_q))) begin
							lim_q <= cnt_q;
						end else begin
							lim_q <= CW'(win_end);
						end
						s_q     <= head_q;
						any_q   <= 1'b0;
						ldu_q   <= '0;
						stu_q   <= '0;
						mfu_q   <= '0;
						fpu_q   <= '0;
						state_q <= S_SCAN_RD;
					end
				end
				S_SCAN_RD: begin
					state_q <= (s_q < lim_q) ? S_SCAN_CHK : S_END;
				end
				S_SCAN_CHK: begin
					if (fin_rd[FW]) begin
						s_q     <= s_q + 1'b1;
						state_q <= S_SCAN_RD;
					end else begin
						cur_kind_q <= kind_rd;
						cur_cnt_q  <= ocnt_rd;
						j_q        <= '0;
						state_q    <= S_OPD_RD;
					end
				end
				S_OPD_RD: begin
					state_q <= (j_q < cur_cnt_q) ? S_OPD_CHK : S_ISSUE;
				end
				S_OPD_CHK: begin
					// producers outside the loaded range count as ready
					if (32'(opd_rd) >= 32'(cnt_q)) begin
						j_q     <= j_q + 1'b1;
						state_q <= S_OPD_RD;
					end else begin
						state_q <= S_DEP_CHK;
					end
				end
				S_DEP_CHK: begin
					if (!fin_rd[FW] || (32'(fin_rd[FW-1:0]) > 32'(t_q))) begin
						s_q     <= s_q + 1'b1;
						state_q <= S_SCAN_RD;
					end else begin
						j_q     <= j_q + 1'b1;
						state_q <= S_OPD_RD;
					end
				end
				S_ISSUE: begin
					if (port_ok) begin
						issued_q <= issued_q + 1'b1;
						any_q    <= 1'b1;
						if (cur_kind_q == K_LOAD) begin
							ldu_q <= ldu_q + 1'b1;
						end
						if (cur_kind_q == K_STORE) begin
							stu_q <= stu_q + 1'b1;
						end
						if (cur_kind_q != K_LOAD && cur_kind_q != K_STORE) begin
							mfu_q <= mfu_q + um;
							fpu_q <= fpu_q + uf;
						end
						if ((cur_kind_q != K_CONST) && (fin_new > mk_q)) begin
							mk_q <= fin_new;
						end
					end
					s_q     <= s_q + 1'b1;
					state_q <= S_SCAN_RD;
				end
				S_END: begin
					if (issued_q == cnt_q) begin
						state_q <= S_FIN;
					end else if (!any_q && (32'(mk_q) <= 32'(t_q))) begin
						// nothing in flight and nothing issuable: stuck for good
						ov_q    <= 1'b1;
						state_q <= S_FIN;
					end else if ((32'(t_q) + 32'd1) >= 32'(HORIZON)) begin
						ov_q    <= 1'b1;
						state_q <= S_FIN;
					end else begin
						t_q     <= t_q + 1'b1;
						state_q <= S_HEAD_RD;
					end
				end
				S_FIN: begin
					if (!out_vq || res_out.ready) begin
						out_vq   <= 1'b1;
						out_mk_q <= (32'(mk_q) > 32'd65535) ? 16'hFFFF : 16'(mk_q);
						out_ov_q <= ov_q;
						cnt_q    <= '0;
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
